// ===== design/wind_rose_histogram_top_assert.svh =====
// Assertion macros for the wind rose histogram block.
// Expects clk and rst in the scope of use.
`ifndef WIND_ROSE_HISTOGRAM_TOP_ASSERT_SVH
`define WIND_ROSE_HISTOGRAM_TOP_ASSERT_SVH

// same-cycle implication
`define WRH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WRH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/wrh_pkg.sv =====
// Shared constants, request codes and types of the wind rose histogram.
// No dependencies.
package wrh_pkg;

  localparam int unsigned DEF_NUM_SECTORS = 16;
  localparam int unsigned DEF_COUNT_WIDTH = 32;
  localparam int unsigned NUM_SPEED_BINS  = 6;

  localparam int unsigned REQ_W       = 2;
  localparam int unsigned STATION_W   = 40;
  localparam int unsigned FIELD13_W   = 13;
  localparam int unsigned SECTOR_W    = 4;
  localparam int unsigned BIN_W       = 3;
  localparam int unsigned OUT_COUNT_W = 32;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [FIELD13_W-1:0] DIR_FULL    = 13'd5760;
  localparam logic [FIELD13_W-1:0] SPEED_LIMIT = 13'd4800;
  localparam logic [FIELD13_W-1:0] SPD_EDGE1   = 13'd80;
  localparam logic [FIELD13_W-1:0] SPD_EDGE2   = 13'd160;
  localparam logic [FIELD13_W-1:0] SPD_EDGE3   = 13'd240;
  localparam logic [FIELD13_W-1:0] SPD_EDGE4   = 13'd400;

  typedef struct packed {
    logic [REQ_W-1:0]    op;
    logic                add_hit;
    logic                rd_hit;
    logic [SECTOR_W-1:0] sector;
    logic [BIN_W-1:0]    speed_bin;
  } wrh_item_t;

  typedef struct packed {
    logic                   accepted;
    logic [SECTOR_W-1:0]    sector;
    logic [BIN_W-1:0]       speed_bin;
    logic [OUT_COUNT_W-1:0] count;
  } wrh_result_t;

  typedef struct packed {
    logic       has_head;
    logic [1:0] count;
  } wrh_q_stat_t;

endpackage

// ===== design/wrh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wrh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/wrh_decode.sv =====
// Request decode: sample filter, speed bin, direction sector, counter address.
// Depends on wrh_pkg.
module wrh_decode #(
  parameter int unsigned NUM_SECTORS = wrh_pkg::DEF_NUM_SECTORS
) (
  input  logic [wrh_pkg::REQ_W-1:0]     req_type,
  input  logic [wrh_pkg::STATION_W-1:0] station_code,
  input  logic [wrh_pkg::STATION_W-1:0] target_station,
  input  logic [wrh_pkg::FIELD13_W-1:0] wind_speed,
  input  logic [wrh_pkg::FIELD13_W-1:0] wind_dir,
  input  logic [wrh_pkg::SECTOR_W-1:0]  read_sector,
  input  logic [wrh_pkg::BIN_W-1:0]     read_bin,
  output wrh_pkg::wrh_item_t            item,
  output logic [$clog2(NUM_SECTORS*wrh_pkg::NUM_SPEED_BINS)-1:0] addr
);
  import wrh_pkg::*;

  localparam int unsigned SIDX_W = $clog2(NUM_SECTORS);
  localparam int unsigned ADDR_W = $clog2(NUM_SECTORS * NUM_SPEED_BINS);

  logic [NUM_SECTORS-1:1] dir_ge;
  logic [SIDX_W-1:0]      dir_sidx;
  logic [BIN_W-1:0]       spd_bin;
  logic                   pass;
  logic                   rd_ok;
  logic [ADDR_W-1:0]      add_addr;
  logic [ADDR_W-1:0]      rd_addr;

  // sector k starts at ceil(k * full / NUM_SECTORS)
  for (genvar k = 1; k < NUM_SECTORS; k++) begin : g_thr
    localparam int unsigned THR = (k * 5760 + NUM_SECTORS - 1) / NUM_SECTORS;
    assign dir_ge[k] = (wind_dir >= THR[FIELD13_W-1:0]);
  end

  always_comb begin
    dir_sidx = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (dir_ge[k]) begin
        dir_sidx = SIDX_W'(k);
      end
    end
    // due north wraps
    if (wind_dir == DIR_FULL) begin
      dir_sidx = '0;
    end
  end

  always_comb begin
    if (wind_speed <= SPD_EDGE1) begin
      spd_bin = 3'd1;
    end else if (wind_speed <= SPD_EDGE2) begin
      spd_bin = 3'd2;
    end else if (wind_speed <= SPD_EDGE3) begin
      spd_bin = 3'd3;
    end else if (wind_speed <= SPD_EDGE4) begin
      spd_bin = 3'd4;
    end else begin
      spd_bin = 3'd5;
    end
  end

  assign pass = (station_code == target_station) && (wind_speed != '0) &&
                (wind_speed < SPEED_LIMIT) && (wind_dir != '0) && (wind_dir <= DIR_FULL);

  assign rd_ok = (32'(read_sector) < NUM_SECTORS) && (32'(read_bin) < NUM_SPEED_BINS);

  assign add_addr = ADDR_W'(dir_sidx) * ADDR_W'(NUM_SPEED_BINS) + ADDR_W'(spd_bin);
  assign rd_addr  = ADDR_W'(SIDX_W'(read_sector)) * ADDR_W'(NUM_SPEED_BINS) +
                    ADDR_W'(read_bin);

  always_comb begin
    item    = '0;
    item.op = req_type;
    addr    = add_addr;
    case (req_type)
      REQ_ADD: begin
        if (pass) begin
          item.add_hit   = 1'b1;
          item.sector    = SECTOR_W'(dir_sidx);
          item.speed_bin = spd_bin;
        end
      end
      REQ_READ: begin
        item.rd_hit    = rd_ok;
        item.sector    = read_sector;
        item.speed_bin = read_bin;
        addr           = rd_addr;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/wrh_outq.sv =====
// Two-entry result queue that feeds the master stream port.
// Depends on wrh_pkg.
module wrh_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wrh_pkg::wrh_result_t din,
  input  logic                 pop,
  output wrh_pkg::wrh_result_t head,
  output wrh_pkg::wrh_q_stat_t stat
);
  import wrh_pkg::*;

  wrh_result_t q0;
  wrh_result_t q1;
  logic [1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          q0 <= din;
        end else begin
          q1 <= din;
        end
      end
      2'b01: begin
        q0 <= q1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          q0 <= din;
        end else begin
          q0 <= q1;
          q1 <= din;
        end
      end
      default: begin
      end
    endcase
  end

  assign head          = q0;
  assign stat.has_head = (count != 2'd0);
  assign stat.count    = count;

endmodule

// ===== design/wind_rose_histogram_top.sv =====
// Wind rose histogram: decode, counter RAM update and result queue.
// tvalid rises once an accepted request passes the s1 register into the result queue.
// Throughput 1 request/cycle; a full result queue stalls the request side.
// Counters live in one RAM with a one-deep write forward for back-to-back updates.
// Reset (rst, synchronous) zeroes all counters at once via per-entry valid bits,
// so no clearing pass is needed; a clear request does the same.
module wind_rose_histogram_top #(
  parameter int unsigned NUM_SECTORS = wrh_pkg::DEF_NUM_SECTORS,
  parameter int unsigned COUNT_WIDTH = wrh_pkg::DEF_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wrh_pkg::STATION_W-1:0]  cfg_wdata,    // target_station
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // station_code, wind_speed, wind_dir, read_sector, read_bin, zero pad
  input  logic [wrh_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [wrh_pkg::REQ_W-1:0]      s_axis_tuser, // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // accepted, sector, speed_bin, count
  output logic [wrh_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import wrh_pkg::*;

  `include "wind_rose_histogram_top_assert.svh"

  localparam int unsigned DEPTH  = NUM_SECTORS * NUM_SPEED_BINS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam int unsigned SPD_LSB = STATION_W;
  localparam int unsigned DIR_LSB = SPD_LSB + FIELD13_W;
  localparam int unsigned RS_LSB  = DIR_LSB + FIELD13_W;
  localparam int unsigned RB_LSB  = RS_LSB + SECTOR_W;

  logic [STATION_W-1:0]   target_station;
  logic                   s_accept;
  wrh_item_t              dec_item;
  logic [ADDR_W-1:0]      dec_addr;

  logic                   s1_valid;
  wrh_item_t              s1_item;
  logic [ADDR_W-1:0]      s1_addr;

  logic [DEPTH-1:0]       valid_bits;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic                   ram_we;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   last_we;
  logic [ADDR_W-1:0]      last_addr;
  logic [COUNT_WIDTH-1:0] last_data;
  logic [COUNT_WIDTH-1:0] cur_raw;
  logic [COUNT_WIDTH-1:0] cur;

  wrh_result_t            s1_res;
  wrh_result_t            q_head;
  wrh_q_stat_t            q_stat;
  logic                   q_pop;
  logic [1:0]             occ_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_station <= '0;
    end else if (cfg_we) begin
      target_station <= cfg_wdata;
    end
  end

  assign s_accept = s_axis_tvalid && s_axis_tready;

  wrh_decode #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_decode (
    .req_type       (s_axis_tuser),
    .station_code   (s_axis_tdata[STATION_W-1:0]),
    .target_station (target_station),
    .wind_speed     (s_axis_tdata[SPD_LSB +: FIELD13_W]),
    .wind_dir       (s_axis_tdata[DIR_LSB +: FIELD13_W]),
    .read_sector    (s_axis_tdata[RS_LSB +: SECTOR_W]),
    .read_bin       (s_axis_tdata[RB_LSB +: BIN_W]),
    .item           (dec_item),
    .addr           (dec_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_item <= dec_item;
      s1_addr <= dec_addr;
    end
  end

  wrh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .re    (s_accept),
    .raddr (dec_addr),
    .rdata (ram_rdata)
  );

  // read was issued while the previous request was writing
  assign cur_raw = (last_we && (last_addr == s1_addr)) ? last_data : ram_rdata;
  assign cur     = valid_bits[s1_addr] ? cur_raw : '0;

  assign ram_we    = s1_valid && s1_item.add_hit;
  assign ram_wdata = (cur == COUNT_MAX) ? cur : cur + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_we    <= 1'b0;
      valid_bits <= '0;
    end else begin
      last_we <= ram_we;
      if (s1_valid && (s1_item.op == REQ_CLEAR)) begin
        valid_bits <= '0;
      end else if (ram_we) begin
        valid_bits[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_addr <= s1_addr;
    last_data <= ram_wdata;
  end

  always_comb begin
    s1_res           = '0;
    s1_res.accepted  = s1_item.add_hit;
    s1_res.sector    = s1_item.sector;
    s1_res.speed_bin = s1_item.speed_bin;
    if (s1_item.add_hit) begin
      s1_res.count = OUT_COUNT_W'(ram_wdata);
    end else if (s1_item.rd_hit) begin
      s1_res.count = OUT_COUNT_W'(cur);
    end
  end

  wrh_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (s1_valid),
    .din  (s1_res),
    .pop  (q_pop),
    .head (q_head),
    .stat (q_stat)
  );

  assign q_pop         = q_stat.has_head && m_axis_tready;
  assign occ_next      = q_stat.count + {1'b0, s1_valid} - {1'b0, q_pop};
  assign s_axis_tready = (occ_next <= 2'd1);

  assign m_axis_tvalid = q_stat.has_head;
  assign m_axis_tdata  = {q_head.count, q_head.speed_bin, q_head.sector, q_head.accepted};

  `WRH_ASSERT_IMP(a_q_room, s1_valid, (q_stat.count != 2'd2) || m_axis_tready, "result queue overflow")
  `WRH_ASSERT_NXT(a_clear_all, s1_valid && (s1_item.op == REQ_CLEAR), valid_bits == '0, "clear missed an entry")
  `WRH_ASSERT_IMP(a_no_wrap, ram_we, ram_wdata != '0, "counter wrapped to zero")
  `WRH_ASSERT_NXT(a_fwd_hold, ram_we, last_we && (last_data == $past(ram_wdata)), "forward register lost write")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for wind_rose_histogram_top: a directed table, then random
// requests in four handshake phases, checked by an in-bench model or typed rows.
// Depends on wrh_pkg and the wind_rose_histogram_top RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wrh_pkg::*;

  localparam int unsigned NSEC = DEF_NUM_SECTORS;
  localparam int unsigned CNT_W = DEF_COUNT_WIDTH;
  localparam int unsigned NCNT = NSEC * NUM_SPEED_BINS;
  localparam logic [63:0] CNT_MAX = (64'd1 << CNT_W) - 64'd1;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [STATION_W-1:0] STN_ALL = 40'hFF_FFFF_FFFF;
  localparam int DIR_N = 25;
  localparam int PHASE_ITEMS = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [REQ_W-1:0]       req;
    logic [STATION_W-1:0]   stn;
    logic [FIELD13_W-1:0]   spd;
    logic [FIELD13_W-1:0]   dir;
    logic [SECTOR_W-1:0]    rs;
    logic [BIN_W-1:0]       rb;
    logic                   typed;
    logic                   acc;
    logic [SECTOR_W-1:0]    sec;
    logic [BIN_W-1:0]       bin;
    logic [OUT_COUNT_W-1:0] cnt;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [STATION_W-1:0]   cfg_wdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [REQ_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [OUT_COUNT_W-1:0] hist_counts [NCNT];
  logic [STATION_W-1:0]   target_stn;
  wrh_result_t            expected_results [$];
  wrh_result_t            got_res;
  wrh_result_t            want_res;
  int                     errors;
  int                     cycle_cnt;
  int                     idle_pct;
  int                     stall_pct;
  logic                   hold_go;
  logic                   hold_taken;
  int                     hold_left;

  int spd_edges [13] = '{0, 1, 80, 81, 160, 161, 240, 241, 400, 401, 4799, 4800, 8191};
  int dir_edges [11] = '{0, 1, 359, 360, 361, 5399, 5400, 5759, 5760, 5761, 8191};

  // fields: req stn spd dir rs rb | typed acc sec bin cnt
  stim_row_t dir_rows [DIR_N] = '{
    '{REQ_READ, 40'd0, 13'd0, 13'd0, 4'd0, 3'd0, 1'b1, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_READ, 40'd0, 13'd0, 13'd0, 4'd15, 3'd7, 1'b1, 1'b0, 4'd15, 3'd7, 32'd0},
    '{REQ_READ, 40'd0, 13'd0, 13'd0, 4'd15, 3'd5, 1'b1, 1'b0, 4'd15, 3'd5, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd1, 13'd1, 4'd0, 3'd0, 1'b1, 1'b1, 4'd0, 3'd1, 32'd1},
    '{REQ_ADD, STN_ALL, 13'd4799, 13'd5760, 4'd0, 3'd0, 1'b1, 1'b1, 4'd0, 3'd5, 32'd1},
    '{REQ_ADD, STN_ALL, 13'd4800, 13'd100, 4'd0, 3'd0, 1'b1, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd0, 13'd100, 4'd0, 3'd0, 1'b1, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd80, 13'd0, 4'd0, 3'd0, 1'b1, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd80, 13'd5761, 4'd0, 3'd0, 1'b1, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd8191, 13'd8191, 4'd15, 3'd7, 1'b1, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, 40'd0, 13'd100, 13'd100, 4'd0, 3'd0, 1'b1, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, 40'h7F_FFFF_FFFF, 13'd100, 13'd100, 4'd0, 3'd0, 1'b1, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd81, 13'd359, 4'd0, 3'd0, 1'b0, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd160, 13'd360, 4'd0, 3'd0, 1'b0, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd161, 13'd5759, 4'd0, 3'd0, 1'b0, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd240, 13'd2880, 4'd0, 3'd0, 1'b0, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd241, 13'd1, 4'd0, 3'd0, 1'b0, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd400, 13'd1, 4'd0, 3'd0, 1'b0, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd401, 13'd1, 4'd0, 3'd0, 1'b0, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_READ, STN_ALL, 13'd8191, 13'd8191, 4'd0, 3'd4, 1'b0, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_READ, 40'd0, 13'd0, 13'd0, 4'd0, 3'd5, 1'b0, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_UNKNOWN, STN_ALL, 13'd8191, 13'd8191, 4'd15, 3'd7,
      1'b1, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_CLEAR, STN_ALL, 13'd8191, 13'd8191, 4'd15, 3'd7, 1'b1, 1'b0, 4'd0, 3'd0, 32'd0},
    '{REQ_READ, 40'd0, 13'd0, 13'd0, 4'd0, 3'd5, 1'b1, 1'b0, 4'd0, 3'd5, 32'd0},
    '{REQ_ADD, STN_ALL, 13'd80, 13'd5760, 4'd0, 3'd0, 1'b1, 1'b1, 4'd0, 3'd1, 32'd1}
  };

  wind_rose_histogram_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results outstanding", $realtime, expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // histogram model: applies one request, returns the result it produces
  function automatic wrh_result_t histo_step(input logic [REQ_W-1:0] req,
                                             input logic [STATION_W-1:0] stn,
                                             input logic [FIELD13_W-1:0] spd,
                                             input logic [FIELD13_W-1:0] dir,
                                             input logic [SECTOR_W-1:0] rs,
                                             input logic [BIN_W-1:0] rb);
    wrh_result_t res;
    int unsigned bin;
    int unsigned sec;
    int unsigned idx;
    res = '0;
    case (req)
      REQ_ADD: begin
        if (stn == target_stn && spd != 0 && spd < SPEED_LIMIT &&
            dir != 0 && dir <= DIR_FULL) begin
          if (spd <= SPD_EDGE1) bin = 1;
          else if (spd <= SPD_EDGE2) bin = 2;
          else if (spd <= SPD_EDGE3) bin = 3;
          else if (spd <= SPD_EDGE4) bin = 4;
          else bin = 5;
          sec = (int'(dir) * NSEC) / int'(DIR_FULL);
          if (sec >= NSEC) sec = 0;  // due north wraps
          idx = sec * NUM_SPEED_BINS + bin;
          if ({32'd0, hist_counts[idx]} < CNT_MAX) hist_counts[idx] = hist_counts[idx] + 1;
          res.accepted = 1'b1;
          res.sector = sec[SECTOR_W-1:0];
          res.speed_bin = bin[BIN_W-1:0];
          res.count = hist_counts[idx];
        end
      end
      REQ_READ: begin
        res.sector = rs;
        res.speed_bin = rb;
        if (rs < NSEC && rb < NUM_SPEED_BINS) res.count = hist_counts[rs * NUM_SPEED_BINS + rb];
      end
      REQ_CLEAR: begin
        for (int i = 0; i < NCNT; i++) hist_counts[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [STATION_W-1:0] stn,
                          input logic [FIELD13_W-1:0] spd, input logic [FIELD13_W-1:0] dir,
                          input logic [SECTOR_W-1:0] rs, input logic [BIN_W-1:0] rb,
                          input logic typed, input wrh_result_t typed_res);
    wrh_result_t pred;
    wrh_result_t want;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {7'd0, rb, rs, dir, spd, stn};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = histo_step(req, stn, spd, dir, rs, rb);
    want = typed ? typed_res : pred;
    expected_results = {expected_results, want};
  endtask

  task automatic gen_random_req();
    int unsigned pick;
    int tmp;
    logic [63:0] rnd;
    logic [REQ_W-1:0] req;
    logic [STATION_W-1:0] stn;
    logic [FIELD13_W-1:0] spd;
    logic [FIELD13_W-1:0] dir;
    pick = $urandom_range(999);
    if (pick < 5) req = REQ_CLEAR;
    else if (pick < 10) req = REQ_UNKNOWN;
    else if (pick < 200) req = REQ_READ;
    else req = REQ_ADD;
    rnd = {$urandom, $urandom};
    case ($urandom_range(9))
      0: stn = rnd[STATION_W-1:0];
      1: stn = target_stn ^ (40'd1 << $urandom_range(STATION_W - 1));
      default: stn = target_stn;
    endcase
    case ($urandom_range(7))
      0: tmp = spd_edges[$urandom_range(12)];
      1: tmp = $urandom_range(8191);
      2: tmp = $urandom_range(4799, 401);
      default: tmp = $urandom_range(600, 1);
    endcase
    spd = tmp[FIELD13_W-1:0];
    case ($urandom_range(7))
      0: tmp = dir_edges[$urandom_range(10)];
      1: tmp = $urandom_range(8191);
      2: tmp = $urandom_range(16) * 360 + $urandom_range(2) - 1;
      default: tmp = $urandom_range(5760, 1);
    endcase
    dir = tmp[FIELD13_W-1:0];
    send_req(req, stn, spd, dir, SECTOR_W'($urandom_range(15)), BIN_W'($urandom_range(7)),
             1'b0, '0);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_target(input logic [STATION_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    target_stn = v;
  endtask

  // result side: check, then pick next tready
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res.accepted = m_axis_tdata[0];
        got_res.sector = m_axis_tdata[4:1];
        got_res.speed_bin = m_axis_tdata[7:5];
        got_res.count = m_axis_tdata[39:8];
        if (expected_results.size() == 0) begin
          errors++;
          if (errors < 20) $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
        end else begin
          want_res = expected_results.pop_front();
          if (got_res !== want_res) begin
            errors++;
            if (errors < 20) begin
              $display("%0t: mismatch expected acc=%0d sec=%0d bin=%0d count=%0d",
                       $realtime, want_res.accepted, want_res.sector, want_res.speed_bin,
                       want_res.count);
              $display("%0t:          actual   acc=%0d sec=%0d bin=%0d count=%0d",
                       $realtime, got_res.accepted, got_res.sector, got_res.speed_bin,
                       got_res.count);
            end
          end
        end
      end
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    stim_row_t row;
    wrh_result_t typed_res;
    logic [63:0] rnd;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    errors = 0;
    cycle_cnt = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    hold_taken = 1'b0;
    hold_left = 0;
    target_stn = '0;
    for (int i = 0; i < NCNT; i++) hist_counts[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_target(STN_ALL);

    for (int i = 0; i < DIR_N; i++) begin
      row = dir_rows[i];
      typed_res.accepted = row.acc;
      typed_res.sector = row.sec;
      typed_res.speed_bin = row.bin;
      typed_res.count = row.cnt;
      send_req(row.req, row.stn, row.spd, row.dir, row.rs, row.rb, row.typed, typed_res);
    end
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      rnd = {$urandom, $urandom};
      case (ph)
        0: begin
          write_target(rnd[STATION_W-1:0]);
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          write_target('0);
          idle_pct = 76;
          stall_pct <= 0;
        end
        2: begin
          write_target(40'h4B_58_59_5A_31);
          idle_pct = 0;
          stall_pct <= 76;
        end
        default: begin
          write_target(STN_ALL);
          idle_pct = 14;
          stall_pct <= 14;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == 100) hold_go <= 1'b1;  // long receiver hold-off
        gen_random_req();
      end
      s_axis_tvalid <= 1'b0;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
